// ----- src/sgm_pkg.sv -----
// Shared types and constants of the Sobel gradient magnitude block.
package sgm_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_W      = 13;
    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int PROD_W     = 2 * GRAD_W;
    localparam int SQ_W       = 21;
    localparam int RAD_W      = 2 * PIX_W;
    localparam int REM_W      = PIX_W + 1;
    localparam int SQRT_STEPS = PIX_W;
    localparam int STEP_W     = $clog2(SQRT_STEPS);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
    localparam logic [CFG_W-1:0] DIM_MIN      = CFG_W'(3);
    localparam logic [CFG_W-1:0] WIDTH_MAX    = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] HEIGHT_MAX   = CFG_W'(MAX_HEIGHT);

    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_GRAD,
        ST_SQR,
        ST_SQRT,
        ST_DONE
    } t_state;

endpackage

// ----- src/sgm_if.sv -----
// Stream interfaces for the pixel input and the magnitude output.
interface sgm_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface sgm_mag_if;
    logic       valid;
    logic       ready;
    logic [7:0] magnitude;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, output magnitude, output row_end, output frame_end,
                    input ready);
    modport sink (input valid, input magnitude, input row_end, input frame_end,
                  output ready);
endinterface

// ----- src/sobel_gradient_magnitude.sv -----
// Top level of the 3x3 Sobel gradient magnitude filter on a raster pixel stream.
//
// Pixels enter in raster order, one transaction each. Two 4096 x 8 single-port line
// stores hold the previous two rows and a 3x3 register window holds the neighborhood.
// Every interior pixel yields floor(sqrt(gx^2 + gy^2)) saturated to 255, with row_end
// and frame_end marks; border pixels yield nothing. A border pixel is accepted and
// then takes a line store read-modify-write. An interior pixel passes through accept,
// line store access, gradient, squares, an 8-step square root unit that resolves
// one result bit per cycle, and the hand-off to the output register. The output
// register lets the next pixel be accepted while a result waits.
// Image width and height are clamped to 3..4096 and may be written only while idle.
module sobel_gradient_magnitude (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [sgm_pkg::CFG_W-1:0]     i_cfg_data,
    sgm_pix_if.sink                       i_pix,
    sgm_mag_if.source                     o_mag
);

    sgm_pkg::t_state r_state;
    sgm_pkg::t_state n_state;

    logic [sgm_pkg::CFG_W-1:0] r_width;
    logic [sgm_pkg::CFG_W-1:0] r_height;
    logic [sgm_pkg::COL_W-1:0] r_col;
    logic [sgm_pkg::ROW_W-1:0] r_row;

    logic [sgm_pkg::COL_W-1:0] r_idx;
    logic [sgm_pkg::PIX_W-1:0] r_pixel;
    logic                      r_last_col;
    logic                      r_last_row;
    logic                      r_emit;

    logic [sgm_pkg::PIX_W-1:0] mem_above [sgm_pkg::MAX_WIDTH];
    logic [sgm_pkg::PIX_W-1:0] mem_middle [sgm_pkg::MAX_WIDTH];
    logic [sgm_pkg::PIX_W-1:0] r_above_q;
    logic [sgm_pkg::PIX_W-1:0] r_middle_q;
    logic [sgm_pkg::COL_W-1:0] mem_addr;
    logic                      mem_we;

    logic [sgm_pkg::PIX_W-1:0] r_win [9];

    logic signed [sgm_pkg::GRAD_W-1:0] r_gx;
    logic signed [sgm_pkg::GRAD_W-1:0] r_gy;
    logic [sgm_pkg::RAD_W-1:0]         r_rad;
    logic                              r_sat;
    logic [sgm_pkg::REM_W-1:0]         r_rem;
    logic [sgm_pkg::PIX_W-1:0]         r_root;
    logic [sgm_pkg::STEP_W-1:0]        r_step;

    logic                      r_out_valid;
    logic [sgm_pkg::PIX_W-1:0] r_mag;
    logic                      r_row_end;
    logic                      r_frame_end;

    logic [sgm_pkg::CFG_W-1:0] w_eff;
    logic [sgm_pkg::CFG_W-1:0] h_eff;
    logic                      last_col;
    logic                      last_row;
    logic                      accept;
    logic                      out_load;
    logic                      sqrt_last;

    logic [sgm_pkg::GRAD_W-1:0]        sum_right;
    logic [sgm_pkg::GRAD_W-1:0]        sum_left;
    logic [sgm_pkg::GRAD_W-1:0]        sum_bottom;
    logic [sgm_pkg::GRAD_W-1:0]        sum_top;
    logic signed [sgm_pkg::PROD_W-1:0] gx_sq;
    logic signed [sgm_pkg::PROD_W-1:0] gy_sq;
    logic [sgm_pkg::SQ_W-1:0]          sq_sum;
    logic [sgm_pkg::PIX_W+2:0]         rem_shift;
    logic [sgm_pkg::PIX_W+2:0]         trial;

    // Effective frame size after clamping to the supported range.
    always_comb begin
        w_eff = r_width;
        if (r_width < sgm_pkg::DIM_MIN) begin
            w_eff = sgm_pkg::DIM_MIN;
        end else if (r_width > sgm_pkg::WIDTH_MAX) begin
            w_eff = sgm_pkg::WIDTH_MAX;
        end
        h_eff = r_height;
        if (r_height < sgm_pkg::DIM_MIN) begin
            h_eff = sgm_pkg::DIM_MIN;
        end else if (r_height > sgm_pkg::HEIGHT_MAX) begin
            h_eff = sgm_pkg::HEIGHT_MAX;
        end
    end

    assign last_col  = {1'b0, r_col} >= (w_eff - sgm_pkg::CFG_W'(1));
    assign last_row  = {1'b0, r_row} >= (h_eff - sgm_pkg::CFG_W'(1));
    assign accept    = i_pix.valid && i_pix.ready;
    assign out_load  = (r_state == sgm_pkg::ST_DONE) && (!r_out_valid || o_mag.ready);
    assign sqrt_last = r_step == sgm_pkg::STEP_W'(sgm_pkg::SQRT_STEPS - 1);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sgm_pkg::WIDTH_RESET;
            r_height <= sgm_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (sgm_pkg::t_cfg_idx'(i_cfg_idx))
                sgm_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                sgm_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgm_pkg::ST_IDLE: if (accept) n_state = sgm_pkg::ST_READ;
            sgm_pkg::ST_READ: n_state = r_emit ? sgm_pkg::ST_GRAD : sgm_pkg::ST_IDLE;
            sgm_pkg::ST_GRAD: n_state = sgm_pkg::ST_SQR;
            sgm_pkg::ST_SQR:  n_state = sgm_pkg::ST_SQRT;
            sgm_pkg::ST_SQRT: if (sqrt_last) n_state = sgm_pkg::ST_DONE;
            sgm_pkg::ST_DONE: if (out_load) n_state = sgm_pkg::ST_IDLE;
            default:          n_state = sgm_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        i_pix.ready = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = r_col;
        unique case (r_state)
            sgm_pkg::ST_IDLE: i_pix.ready = 1'b1;
            sgm_pkg::ST_READ: begin
                mem_we   = 1'b1;
                mem_addr = r_idx;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Position of the next incoming pixel; the pixel's context is latched on accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + sgm_pkg::ROW_W'(1);
            end else begin
                r_col <= r_col + sgm_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx      <= r_col;
            r_pixel    <= i_pix.pixel;
            r_last_col <= last_col;
            r_last_row <= last_row;
            r_emit     <= (r_row >= sgm_pkg::ROW_W'(2)) && (r_col >= sgm_pkg::COL_W'(2));
        end
    end

    // Line stores: read at accept, written back in the following cycle at the same column.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_above[mem_addr] <= r_middle_q;
        end
        r_above_q <= mem_above[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_middle[mem_addr] <= r_pixel;
        end
        r_middle_q <= mem_middle[mem_addr];
    end

    // 3x3 window, indexed row * 3 + column with the newest column on the right.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_state == sgm_pkg::ST_READ) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= r_above_q;
            r_win[5] <= r_middle_q;
            r_win[8] <= r_pixel;
        end
    end

    assign sum_right  = sgm_pkg::GRAD_W'(r_win[2]) + {2'b0, r_win[5], 1'b0}
                      + sgm_pkg::GRAD_W'(r_win[8]);
    assign sum_left   = sgm_pkg::GRAD_W'(r_win[0]) + {2'b0, r_win[3], 1'b0}
                      + sgm_pkg::GRAD_W'(r_win[6]);
    assign sum_bottom = sgm_pkg::GRAD_W'(r_win[6]) + {2'b0, r_win[7], 1'b0}
                      + sgm_pkg::GRAD_W'(r_win[8]);
    assign sum_top    = sgm_pkg::GRAD_W'(r_win[0]) + {2'b0, r_win[1], 1'b0}
                      + sgm_pkg::GRAD_W'(r_win[2]);

    // The gradients are sign-extended first so that each square keeps all of its bits.
    assign gx_sq  = sgm_pkg::PROD_W'(r_gx) * sgm_pkg::PROD_W'(r_gx);
    assign gy_sq  = sgm_pkg::PROD_W'(r_gy) * sgm_pkg::PROD_W'(r_gy);
    assign sq_sum = sgm_pkg::SQ_W'($unsigned(gx_sq)) + sgm_pkg::SQ_W'($unsigned(gy_sq));

    // Square root: two radicand bits enter the remainder and one root bit resolves per step.
    assign rem_shift = {r_rem, r_rad[sgm_pkg::RAD_W-1 -: 2]};
    assign trial     = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            sgm_pkg::ST_GRAD: begin
                r_gx <= $signed(sum_right - sum_left);
                r_gy <= $signed(sum_bottom - sum_top);
            end
            sgm_pkg::ST_SQR: begin
                r_rad  <= sq_sum[sgm_pkg::RAD_W-1:0];
                r_sat  <= |sq_sum[sgm_pkg::SQ_W-1:sgm_pkg::RAD_W];
                r_rem  <= '0;
                r_root <= '0;
                r_step <= '0;
            end
            sgm_pkg::ST_SQRT: begin
                r_rad  <= {r_rad[sgm_pkg::RAD_W-3:0], 2'b00};
                r_step <= r_step + sgm_pkg::STEP_W'(1);
                if (rem_shift >= trial) begin
                    r_rem  <= sgm_pkg::REM_W'(rem_shift - trial);
                    r_root <= {r_root[sgm_pkg::PIX_W-2:0], 1'b1};
                end else begin
                    r_rem  <= sgm_pkg::REM_W'(rem_shift);
                    r_root <= {r_root[sgm_pkg::PIX_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_mag.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_mag       <= r_sat ? '1 : r_root;
            r_row_end   <= r_last_col;
            r_frame_end <= r_last_col && r_last_row;
        end
    end

    assign o_mag.valid     = r_out_valid;
    assign o_mag.magnitude = r_mag;
    assign o_mag.row_end   = r_row_end;
    assign o_mag.frame_end = r_frame_end;

`ifndef SYNTHESIS
    a_frame_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mag.valid && o_mag.frame_end |-> o_mag.row_end)
        else $error("frame_end without row_end");

    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == sgm_pkg::ST_READ)
        else $error("accepted pixel did not start a line store access");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == sgm_pkg::ST_DONE)
        else $error("output register loaded outside the result hand-off");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the Sobel gradient magnitude filter.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    // An interior pixel keeps the block busy longer than a border pixel.
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_PIXELS  = 150;

    typedef struct packed {
        logic [sgm_pkg::PIX_W-1:0] magnitude;
        logic                      row_end;
        logic                      frame_end;
    } t_mag_result;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_SMOOTH,
        FILL_BINARY
    } t_fill;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic                      i_cfg_idx;
    logic [sgm_pkg::CFG_W-1:0] i_cfg_data;

    sgm_pix_if pix_bus ();
    sgm_mag_if mag_bus ();

    sobel_gradient_magnitude u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_bus),
        .o_mag      (mag_bus)
    );

    // Predictor state: line stores, 3x3 neighborhood, raster position and registers.
    logic [sgm_pkg::PIX_W-1:0] above_row  [sgm_pkg::MAX_WIDTH] = '{default: '0};
    logic [sgm_pkg::PIX_W-1:0] middle_row [sgm_pkg::MAX_WIDTH] = '{default: '0};
    logic [sgm_pkg::PIX_W-1:0] nbhd [3][3]                     = '{default: '0};
    int unsigned               next_col   = 0;
    int unsigned               next_row   = 0;
    logic [sgm_pkg::CFG_W-1:0] reg_width  = sgm_pkg::WIDTH_RESET;
    logic [sgm_pkg::CFG_W-1:0] reg_height = sgm_pkg::HEIGHT_RESET;

    t_mag_result               pending_mags [$];
    int unsigned               mismatch_count = 0;
    int unsigned               results_seen   = 0;
    int unsigned               pixels_sent    = 0;
    int unsigned               stalled_cycles = 0;
    bit                        idle_en        = 1'b0;
    t_fill                     fill_mode      = FILL_RANDOM;
    logic [sgm_pkg::PIX_W-1:0] smooth_base    = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_dim(input int unsigned value, input int unsigned hi);
        if (value < 3) return 3;
        if (value > hi) return hi;
        return value;
    endfunction

    function automatic logic [sgm_pkg::PIX_W-1:0] floor_sqrt(input int unsigned sum_sq);
        logic [sgm_pkg::PIX_W-1:0] root;
        int unsigned               trial;
        root = '0;
        for (int b = sgm_pkg::PIX_W - 1; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= sum_sq) root[b] = 1'b1;
        end
        return root;
    endfunction

    function automatic void predict_pixel(input logic [sgm_pkg::PIX_W-1:0] bot);
        int unsigned               w;
        int unsigned               h;
        int unsigned               slot;
        logic [sgm_pkg::PIX_W-1:0] top;
        logic [sgm_pkg::PIX_W-1:0] mid;
        int                        gx;
        int                        gy;
        int unsigned               sum_sq;
        logic                      last_col;
        logic                      last_row;
        t_mag_result               res;
        w    = clamp_dim(reg_width, sgm_pkg::MAX_WIDTH);
        h    = clamp_dim(reg_height, sgm_pkg::MAX_HEIGHT);
        slot = (next_col < sgm_pkg::MAX_WIDTH) ? next_col : sgm_pkg::MAX_WIDTH - 1;
        top  = above_row[slot];
        mid  = middle_row[slot];
        above_row[slot]  = mid;
        middle_row[slot] = bot;
        for (int r = 0; r < 3; r++) begin
            nbhd[r][0] = nbhd[r][1];
            nbhd[r][1] = nbhd[r][2];
        end
        nbhd[0][2] = top;
        nbhd[1][2] = mid;
        nbhd[2][2] = bot;
        last_col = (next_col >= w - 1);
        last_row = (next_row >= h - 1);
        if (next_row >= 2 && next_col >= 2) begin
            gx = (int'(nbhd[0][2]) + 2 * int'(nbhd[1][2]) + int'(nbhd[2][2]))
               - (int'(nbhd[0][0]) + 2 * int'(nbhd[1][0]) + int'(nbhd[2][0]));
            gy = (int'(nbhd[2][0]) + 2 * int'(nbhd[2][1]) + int'(nbhd[2][2]))
               - (int'(nbhd[0][0]) + 2 * int'(nbhd[0][1]) + int'(nbhd[0][2]));
            sum_sq = gx * gx + gy * gy;
            res.magnitude = (sum_sq >= 65536) ? 8'hFF : floor_sqrt(sum_sq);
            res.row_end   = last_col;
            res.frame_end = last_col && last_row;
            pending_mags.push_back(res);
        end
        if (last_col) begin
            next_col = 0;
            next_row = last_row ? 0 : next_row + 1;
        end else begin
            next_col = next_col + 1;
        end
    endfunction

    function automatic logic [sgm_pkg::PIX_W-1:0] next_pixel();
        case (fill_mode)
            FILL_SMOOTH: return smooth_base + sgm_pkg::PIX_W'($urandom_range(0, 15));
            FILL_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:     return sgm_pkg::PIX_W'($urandom);
        endcase
    endfunction

    task automatic pick_fill();
        fill_mode   = t_fill'($urandom_range(0, 2));
        smooth_base = sgm_pkg::PIX_W'($urandom_range(0, 240));
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Valid stays high into the next transaction unless an idle burst follows.
    task automatic send_pixel(input logic [sgm_pkg::PIX_W-1:0] value);
        pix_bus.valid <= 1'b1;
        pix_bus.pixel <= value;
        @(posedge i_clk);
        while (pix_bus.ready !== 1'b1) @(posedge i_clk);
        predict_pixel(value);
        pixels_sent++;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            pix_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic send_frame_rest();
        do begin
            send_pixel(next_pixel());
        end while (next_col != 0 || next_row != 0);
    endtask

    task automatic wait_idle();
        pix_bus.valid <= 1'b0;
        while (pending_mags.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input sgm_pkg::t_cfg_idx idx, input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= sgm_pkg::CFG_W'(value);
        @(posedge i_clk);
        if (idx == sgm_pkg::CFG_IMAGE_WIDTH) reg_width = sgm_pkg::CFG_W'(value);
        else reg_height = sgm_pkg::CFG_W'(value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reset values of the registers: the first row wraps after 640 pixels and no frame
    // end shows in the following rows, then a height cut while the frame is in flight.
    task automatic test_reset_defaults();
        idle_en = 1'b1;
        pick_fill();
        repeat (int'(sgm_pkg::WIDTH_RESET) + 1) send_pixel(next_pixel());
        wait_idle();
        write_reg(sgm_pkg::CFG_IMAGE_WIDTH, 3);
        repeat (14) send_pixel(next_pixel());
        wait_idle();
        write_reg(sgm_pkg::CFG_IMAGE_HEIGHT, 3);
        send_frame_rest();
        wait_idle();
    endtask

    // Extreme pixel values: flat maximum, the exact saturation threshold, negative gradients.
    task automatic test_gradient_extremes();
        logic [sgm_pkg::PIX_W-1:0] frames [3][9];
        frames = '{
            '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
            '{8'd0,   8'd0,   8'd64,  8'd0,   8'd0,   8'd64,  8'd0,   8'd0,   8'd64},
            '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0}
        };
        idle_en = 1'b0;
        write_reg(sgm_pkg::CFG_IMAGE_WIDTH, 3);
        write_reg(sgm_pkg::CFG_IMAGE_HEIGHT, 3);
        for (int f = 0; f < 3; f++) begin
            for (int p = 0; p < 9; p++) send_pixel(frames[f][p]);
        end
        wait_idle();
    endtask

    // Width cut past the current column, height cut past the current row, then height raised.
    task automatic test_midframe_resize();
        idle_en = 1'b1;
        pick_fill();
        write_reg(sgm_pkg::CFG_IMAGE_WIDTH, 10);
        write_reg(sgm_pkg::CFG_IMAGE_HEIGHT, 8);
        repeat (36) send_pixel(next_pixel());
        wait_idle();
        write_reg(sgm_pkg::CFG_IMAGE_WIDTH, 4);
        repeat (9) send_pixel(next_pixel());
        wait_idle();
        write_reg(sgm_pkg::CFG_IMAGE_HEIGHT, 4);
        send_frame_rest();
        wait_idle();
        write_reg(sgm_pkg::CFG_IMAGE_WIDTH, 5);
        write_reg(sgm_pkg::CFG_IMAGE_HEIGHT, 3);
        repeat (10) send_pixel(next_pixel());
        wait_idle();
        write_reg(sgm_pkg::CFG_IMAGE_HEIGHT, 6);
        send_frame_rest();
        wait_idle();
    endtask

    // Register values below and above the legal range.
    task automatic test_dimension_clamp();
        idle_en = 1'b1;
        pick_fill();
        write_reg(sgm_pkg::CFG_IMAGE_WIDTH, 0);
        write_reg(sgm_pkg::CFG_IMAGE_HEIGHT, 1);
        send_frame_rest();
        wait_idle();
        write_reg(sgm_pkg::CFG_IMAGE_WIDTH, 2);
        write_reg(sgm_pkg::CFG_IMAGE_HEIGHT, 2);
        send_frame_rest();
        wait_idle();
        // Oversized values clamp to the largest frame, so nothing wraps early.
        pick_fill();
        write_reg(sgm_pkg::CFG_IMAGE_WIDTH, (1 << sgm_pkg::CFG_W) - 1);
        write_reg(sgm_pkg::CFG_IMAGE_HEIGHT, (1 << sgm_pkg::CFG_W) - 1);
        repeat (6) send_pixel(next_pixel());
        wait_idle();
        write_reg(sgm_pkg::CFG_IMAGE_WIDTH, 4);
        repeat (13) send_pixel(next_pixel());
        wait_idle();
        write_reg(sgm_pkg::CFG_IMAGE_HEIGHT, 5);
        send_frame_rest();
        wait_idle();
    endtask

    task automatic test_random_frames(input int unsigned n_pixels);
        int unsigned stop_at;
        int unsigned w_val;
        int unsigned h_val;
        int unsigned area;
        stop_at = pixels_sent + n_pixels;
        while (pixels_sent < stop_at) begin
            idle_en = ($urandom_range(0, 3) != 0);
            pick_fill();
            case ($urandom_range(0, 19))
                0:       w_val = $urandom_range(13, 30);
                1, 2, 3: w_val = $urandom_range(7, 12);
                default: w_val = $urandom_range(0, 6);
            endcase
            h_val = $urandom_range(0, 6);
            write_reg(sgm_pkg::CFG_IMAGE_WIDTH, w_val);
            write_reg(sgm_pkg::CFG_IMAGE_HEIGHT, h_val);
            if ($urandom_range(0, 3) == 0) begin
                // Stop inside the frame; the width never grows here.
                area = clamp_dim(w_val, sgm_pkg::MAX_WIDTH)
                     * clamp_dim(h_val, sgm_pkg::MAX_HEIGHT);
                repeat ($urandom_range(1, area - 1)) send_pixel(next_pixel());
                wait_idle();
                if ($urandom_range(0, 1) == 0)
                    write_reg(sgm_pkg::CFG_IMAGE_WIDTH,
                              $urandom_range(0, clamp_dim(w_val, sgm_pkg::MAX_WIDTH)));
                else
                    write_reg(sgm_pkg::CFG_IMAGE_HEIGHT, $urandom_range(0, 10));
            end
            send_frame_rest();
            wait_idle();
        end
    endtask

    // Back-to-back frames with pixels always valid and results always taken.
    task automatic test_full_rate();
        idle_en = 1'b0;
        write_reg(sgm_pkg::CFG_IMAGE_WIDTH, 7);
        write_reg(sgm_pkg::CFG_IMAGE_HEIGHT, 6);
        repeat (2) begin
            pick_fill();
            send_frame_rest();
        end
        wait_idle();
    endtask

    initial begin
        mag_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (idle_en && $urandom_range(0, 7) == 0) begin
                mag_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            mag_bus.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_mag_result want;
        if (i_rst_n && mag_bus.valid === 1'b1 && mag_bus.ready === 1'b1) begin
            results_seen++;
            if (pending_mags.size() == 0) begin
                report_mismatch($sformatf("result %0d (magnitude %0d) with nothing pending",
                                          results_seen, mag_bus.magnitude));
            end else begin
                want = pending_mags.pop_front();
                if (mag_bus.magnitude !== want.magnitude)
                    report_mismatch($sformatf("result %0d magnitude %0d, expected %0d",
                                              results_seen, mag_bus.magnitude, want.magnitude));
                if (mag_bus.row_end !== want.row_end)
                    report_mismatch($sformatf("result %0d row_end %b, expected %b",
                                              results_seen, mag_bus.row_end, want.row_end));
                if (mag_bus.frame_end !== want.frame_end)
                    report_mismatch($sformatf("result %0d frame_end %b, expected %b",
                                              results_seen, mag_bus.frame_end, want.frame_end));
            end
        end
    end

    // Any transaction or register write counts as progress.
    always @(posedge i_clk) begin
        if ((pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1)
                || (mag_bus.valid === 1'b1 && mag_bus.ready === 1'b1) || i_cfg_we) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= sgm_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data    <= '0;
        pix_bus.valid <= 1'b0;
        pix_bus.pixel <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_gradient_extremes();
        test_midframe_resize();
        test_dimension_clamp();
        test_random_frames(RANDOM_PIXELS);
        test_full_rate();

        if (mismatch_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
